// File: rtl/core/ccs_pkg.sv
// Shared types and constants for the comment and blank line stripper.
package ccs_pkg;

  // Depth of the result queue between the lexer and the output side.
  localparam int QUEUE_DEPTH = 4;

  // One result item as it leaves the block.
  typedef struct packed {
    logic       newline_before;
    logic [7:0] spaces_before;
    logic       has_byte;
    logic [7:0] out_byte;
    logic       last;
  } ccs_result_t;

  // All results caused by one input byte: one or two.
  typedef struct packed {
    logic        two;
    ccs_result_t first;
    ccs_result_t second;
  } ccs_entry_t;

  // Pending whitespace state of the lexer.
  typedef struct packed {
    logic       pnl;
    logic [7:0] psp;
    logic       afs;
  } ccs_pend_t;

  // Outcome of handing one character to the whitespace tracker.
  typedef struct packed {
    ccs_pend_t   st;
    logic        emit;
    ccs_result_t res;
  } ccs_put_t;

endpackage

// File: rtl/core/ccs_if.sv
// Handshake interfaces for the source text channel and the result channel.
interface ccs_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface ccs_result_if;
  logic       valid;
  logic       ready;
  logic       newline_before;
  logic [7:0] spaces_before;
  logic       has_byte;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output newline_before, output spaces_before,
                  output has_byte, output out_byte, output last, input ready);
  modport sink (input valid, input newline_before, input spaces_before,
                input has_byte, input out_byte, input last, output ready);
endinterface

// File: rtl/core/ccs_front.sv
// Lexer front end: accepts source bytes and queues the results they cause.
module ccs_front
  import ccs_pkg::*;
#(
  parameter int unsigned MAX_SPACES = 255
) (
  input  logic         clk,
  input  logic         rst,
  ccs_text_if.sink     text,
  input  logic         full,
  output logic         push,
  output ccs_entry_t   push_data
);

  localparam logic [7:0] SPACE_CAP = (MAX_SPACES < 255) ? 8'(MAX_SPACES) : 8'd255;

  localparam logic [2:0] M_NORMAL = 3'd0;
  localparam logic [2:0] M_SLASH  = 3'd1;
  localparam logic [2:0] M_LINE   = 3'd2;
  localparam logic [2:0] M_BLOCK  = 3'd3;
  localparam logic [2:0] M_BSTAR  = 3'd4;
  localparam logic [2:0] M_STRING = 3'd5;
  localparam logic [2:0] M_ESC    = 3'd6;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam ccs_pend_t PEND_RESET = '{pnl: 1'b0, psp: 8'd0, afs: 1'b1};

  logic [2:0] mode, mode_next;
  ccs_pend_t  pend, pend_next;
  logic       accept;

  // Blanks are counted, newlines become pending, anything else is emitted.
  function automatic ccs_put_t put_char(input ccs_pend_t st, input logic [7:0] b);
    ccs_put_t p;
    p.st   = st;
    p.emit = 1'b0;
    p.res  = '0;
    if (b == CH_SPACE || b == CH_TAB) begin
      if (st.psp < SPACE_CAP) p.st.psp = st.psp + 8'd1;
    end else if (b == CH_NL) begin
      if (!st.afs) p.st.pnl = 1'b1;
      p.st.psp = 8'd0;
    end else begin
      p.emit               = 1'b1;
      p.res.newline_before = st.pnl;
      p.res.spaces_before  = st.psp;
      p.res.has_byte       = 1'b1;
      p.res.out_byte       = b;
      p.st                 = '{pnl: 1'b0, psp: 8'd0, afs: 1'b0};
    end
    return p;
  endfunction

  // No request is taken while the block is held in reset.
  assign text.ready = !full && !rst;
  assign accept     = text.valid && text.ready;

  // Next lexer state and the results of the current byte.
  always_comb begin
    ccs_put_t    p0;
    ccs_put_t    p1;
    logic        e0;
    logic        e1;
    ccs_result_t r0;
    ccs_result_t r1;
    logic [7:0]  b;
    b         = text.in_byte;
    mode_next = mode;
    pend_next = pend;
    e0        = 1'b0;
    e1        = 1'b0;
    r0        = '0;
    r1        = '0;
    p0        = '0;
    p1        = '0;
    if (text.end_of_input) begin
      // End of file flushes a pending slash or a pending newline.
      if (mode == M_SLASH) begin
        e0 = 1'b1;
        r0 = '{newline_before: pend.pnl, spaces_before: pend.psp, has_byte: 1'b1,
               out_byte: CH_SLASH, last: 1'b0};
      end else if (pend.pnl) begin
        e0 = 1'b1;
        r0 = '{newline_before: 1'b1, spaces_before: 8'd0, has_byte: 1'b0,
               out_byte: 8'd0, last: 1'b0};
      end
      mode_next = M_NORMAL;
      pend_next = PEND_RESET;
    end else begin
      unique case (mode)
        M_SLASH: begin
          if (b == CH_SLASH) begin
            mode_next = M_LINE;
          end else if (b == CH_STAR) begin
            mode_next = M_BLOCK;
          end else begin
            // A lone slash is emitted, then the byte is taken as normal text.
            p0        = put_char(pend, CH_SLASH);
            p1        = put_char(p0.st, b);
            e0        = p0.emit;
            r0        = p0.res;
            e1        = p1.emit;
            r1        = p1.res;
            pend_next = p1.st;
            mode_next = (b == CH_QUOTE) ? M_STRING : M_NORMAL;
          end
        end
        M_LINE: begin
          if (b == CH_NL) begin
            p0        = put_char(pend, b);
            pend_next = p0.st;
            mode_next = M_NORMAL;
          end
        end
        M_BLOCK: begin
          if (b == CH_STAR) mode_next = M_BSTAR;
        end
        M_BSTAR: begin
          if (b == CH_SLASH) mode_next = M_NORMAL;
          else if (b != CH_STAR) mode_next = M_BLOCK;
        end
        M_STRING: begin
          p0        = put_char(pend, b);
          e0        = p0.emit;
          r0        = p0.res;
          pend_next = p0.st;
          if (b == CH_QUOTE || b == CH_NL) mode_next = M_NORMAL;
          else if (b == CH_BSL) mode_next = M_ESC;
        end
        M_ESC: begin
          p0        = put_char(pend, b);
          e0        = p0.emit;
          r0        = p0.res;
          pend_next = p0.st;
          mode_next = M_STRING;
        end
        default: begin
          if (b == CH_SLASH) begin
            mode_next = M_SLASH;
          end else begin
            p0        = put_char(pend, b);
            e0        = p0.emit;
            r0        = p0.res;
            pend_next = p0.st;
            mode_next = (b == CH_QUOTE) ? M_STRING : M_NORMAL;
          end
        end
      endcase
    end
    // Mark the final result of this byte.
    r0.last          = !e1;
    r1.last          = 1'b1;
    push             = accept && e0;
    push_data.two    = e1;
    push_data.first  = r0;
    push_data.second = r1;
  end

  // Lexer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_NORMAL;
      pend <= PEND_RESET;
    end else if (accept) begin
      mode <= mode_next;
      pend <= pend_next;
    end
  end

endmodule

// File: rtl/core/ccs_queue.sv
// Short result queue between the lexer and the output side.
module ccs_queue
  import ccs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ccs_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output ccs_entry_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  ccs_entry_t       store [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == DEPTH_CNT);
  assign empty = (count == '0);
  assign head  = store[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

// File: rtl/core/ccs_back.sv
// Output side: delivers the queued results one request at a time.
module ccs_back
  import ccs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  ccs_entry_t    head,
  output logic          pop,
  ccs_result_if.source  result
);

  logic        second;
  logic        fire;
  ccs_result_t cur;

  assign cur   = second ? head.second : head.first;
  assign fire  = result.valid && result.ready;
  assign pop   = fire && (!head.two || second);

  assign result.valid          = !empty;
  assign result.newline_before = cur.newline_before;
  assign result.spaces_before  = cur.spaces_before;
  assign result.has_byte       = cur.has_byte;
  assign result.out_byte       = cur.out_byte;
  assign result.last           = cur.last;

  // Steps through the second result of a two-result entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (fire) begin
      second <= head.two && !second;
    end
  end

endmodule

// File: rtl/core/c_comment_and_blank_line_stripper_unit.sv
// Stripper of C comments and blank lines: top level.
// The block takes one source byte per cycle and gives its results one request per cycle
// while the result side is ready, registered through a four-entry result queue. Most bytes
// cause no result or one; a lone slash followed by a visible byte causes two, which the
// output side delivers one after the other, so input accepts at one byte per cycle as long
// as the queue has room, and the queue fill is what holds the input back when the result
// side stalls. Spaces and tabs are counted up to the smaller of MAX_SPACES and 255. An
// end-of-input request flushes a pending slash or newline and returns the block to its reset state for the next file.
module c_comment_and_blank_line_stripper_unit
  import ccs_pkg::*;
#(
  parameter int unsigned MAX_SPACES = 255
) (
  input  logic         clk,
  input  logic         rst,
  ccs_text_if.sink     text,
  ccs_result_if.source result
);

  logic       push;
  ccs_entry_t push_data;
  logic       full;
  logic       pop;
  logic       empty;
  ccs_entry_t head;

  ccs_front #(
    .MAX_SPACES (MAX_SPACES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .text      (text),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  ccs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  ccs_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

// File: dv/tb_c_comment_and_blank_line_stripper_unit.sv
// Testbench for the C comment and blank line stripper: stimulus, prediction and checking.
`timescale 1ns / 100ps

module tb_c_comment_and_blank_line_stripper_unit;
  import ccs_pkg::*;

  localparam int SPACE_CAP   = 255;
  localparam int ITEM_TARGET = 1200;
  localparam int TAIL_ITEMS  = 150;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_WAIT  = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 10;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Lexer modes of the predictor.
  typedef enum logic [2:0] {
    LX_NORMAL, LX_SLASH, LX_LINE, LX_BLOCK, LX_BSTAR, LX_STRING, LX_ESCAPE
  } lex_mode_e;

  // One request on the text channel.
  typedef struct packed {
    logic       eoi;
    logic [7:0] ch;
  } text_req_t;

  logic clk;
  logic rst;

  ccs_text_if   text_ch ();
  ccs_result_if result_ch ();

  c_comment_and_blank_line_stripper_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  // Source text waiting to be sent and result requests the block still owes us.
  text_req_t   source_bytes[$];
  ccs_result_t expected_tokens[$];

  // Predictor state.
  lex_mode_e   lex_mode   = LX_NORMAL;
  logic        pend_nl    = 1'b0;
  logic [7:0]  pend_sp    = '0;
  logic        file_start = 1'b1;
  ccs_result_t step_res[2];
  int          step_n;

  // Bookkeeping shared between the processes.
  logic        text_taken     = 1'b0;
  int          accepted_count = 0;
  int          cycle_count    = 0;
  int          err_count      = 0;
  int          gap_left       = 0;
  int          stall_left     = 0;
  int          hold_left      = 0;
  logic        hold_done      = 1'b0;
  text_req_t   next_req;
  ccs_result_t got;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void add_token(logic nl, logic [7:0] sp, logic has, logic [7:0] b);
    if (step_n < 2) begin
      step_res[step_n] = '{newline_before: nl, spaces_before: sp, has_byte: has,
                           out_byte: b, last: 1'b0};
      step_n++;
    end
  endfunction

  function automatic void reset_lexer();
    lex_mode   = LX_NORMAL;
    pend_nl    = 1'b0;
    pend_sp    = '0;
    file_start = 1'b1;
  endfunction

  // Blanks and newlines only update the pending state; anything else is a visible byte.
  function automatic void track_char(logic [7:0] b);
    if (b == CH_SPACE || b == CH_TAB) begin
      if (pend_sp < SPACE_CAP) pend_sp++;
    end else if (b == CH_NL) begin
      if (!file_start) pend_nl = 1'b1;
      pend_sp = '0;
    end else begin
      add_token(pend_nl, pend_sp, 1'b1, b);
      pend_nl    = 1'b0;
      pend_sp    = '0;
      file_start = 1'b0;
    end
  endfunction

  function automatic void normal_char(logic [7:0] b);
    if (b == CH_SLASH) begin
      lex_mode = LX_SLASH;
    end else if (b == CH_QUOTE) begin
      track_char(b);
      lex_mode = LX_STRING;
    end else begin
      track_char(b);
      lex_mode = LX_NORMAL;
    end
  endfunction

  // Works out the result requests caused by one accepted request and queues them.
  function automatic void predict_request(text_req_t req);
    step_n = 0;
    if (req.eoi) begin
      // End of file flushes a held slash, or else a pending newline on its own.
      if (lex_mode == LX_SLASH) add_token(pend_nl, pend_sp, 1'b1, CH_SLASH);
      else if (pend_nl) add_token(1'b1, '0, 1'b0, '0);
      reset_lexer();
    end else begin
      case (lex_mode)
        LX_SLASH: begin
          if (req.ch == CH_SLASH) lex_mode = LX_LINE;
          else if (req.ch == CH_STAR) lex_mode = LX_BLOCK;
          else begin
            // A lone slash is kept and the byte after it is lexed as normal text.
            track_char(CH_SLASH);
            normal_char(req.ch);
          end
        end
        LX_LINE: begin
          if (req.ch == CH_NL) begin
            track_char(req.ch);
            lex_mode = LX_NORMAL;
          end
        end
        LX_BLOCK: begin
          if (req.ch == CH_STAR) lex_mode = LX_BSTAR;
        end
        LX_BSTAR: begin
          if (req.ch == CH_SLASH) lex_mode = LX_NORMAL;
          else if (req.ch != CH_STAR) lex_mode = LX_BLOCK;
        end
        LX_STRING: begin
          track_char(req.ch);
          if (req.ch == CH_QUOTE || req.ch == CH_NL) lex_mode = LX_NORMAL;
          else if (req.ch == CH_BSL) lex_mode = LX_ESCAPE;
        end
        LX_ESCAPE: begin
          track_char(req.ch);
          lex_mode = LX_STRING;
        end
        default: normal_char(req.ch);
      endcase
    end
    for (int i = 0; i < step_n; i++) begin
      if (i == step_n - 1) step_res[i].last = 1'b1;
      expected_tokens.push_back(step_res[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  task automatic add_byte(logic [7:0] b);
    source_bytes.push_back('{eoi: 1'b0, ch: b});
  endtask

  task automatic add_eoi();
    text_req_t req;
    req.eoi = 1'b1;
    req.ch  = 8'($urandom_range(0, 255));
    source_bytes.push_back(req);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Any byte but a newline, so a line comment keeps running.
  function automatic logic [7:0] comment_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_NL) b = CH_SPACE;
    return b;
  endfunction

  // One source file made of mostly well-formed tokens with random content.
  task automatic add_file();
    int n_tok;
    int pick;
    int n;
    n_tok = $urandom_range(8, 40);
    for (int t = 0; t < n_tok; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) add_byte(8'($urandom_range(48, 57)));
          else add_byte(8'($urandom_range(97, 122)));
        end
      end else if (pick < 42) begin
        // Blank runs, now and then long enough to saturate the count.
        n = ($urandom_range(0, 39) == 0) ? $urandom_range(256, 300) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      end else if (pick < 52) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) add_byte(CH_NL);
      end else if (pick < 60) begin
        add_byte(CH_SLASH);
        add_byte(CH_SLASH);
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) add_byte(comment_byte());
        add_byte(CH_NL);
      end else if (pick < 68) begin
        add_byte(CH_SLASH);
        add_byte(CH_STAR);
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) add_byte(CH_STAR);
          else add_byte(comment_byte());
        end
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) add_byte(CH_STAR);
        add_byte(CH_SLASH);
      end else if (pick < 76) begin
        add_byte(CH_QUOTE);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) begin
            add_byte(CH_BSL);
            add_byte(8'($urandom_range(0, 255)));
          end else begin
            add_byte(8'($urandom_range(32, 126)));
          end
        end
        add_byte(($urandom_range(0, 4) == 0) ? CH_NL : CH_QUOTE);
      end else if (pick < 82) begin
        add_byte(CH_SLASH);
        add_byte(8'($urandom_range(33, 126)));
      end else if (pick < 88) begin
        add_byte($urandom_range(0, 1) ? CH_STAR : 8'($urandom_range(33, 64)));
      end else if (pick < 97) begin
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        // File cut off in whatever state the lexer happens to be in.
        add_eoi();
      end
    end
    if ($urandom_range(0, 5) == 0) add_byte(CH_SLASH);
    if ($urandom_range(0, 3) == 0) add_byte(CH_NL);
    add_eoi();
  endtask

  // ---------------------------------------------------------------------------
  // Text driver: holds each request until it is taken, with random gaps.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      text_ch.valid <= 1'b0;
    end else if (!text_ch.valid || text_taken) begin
      if (gap_left != 0) begin
        text_ch.valid <= 1'b0;
        gap_left--;
      end else if (source_bytes.size() == 0) begin
        text_ch.valid <= 1'b0;
      end else if (source_bytes.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(0, 18);
        text_ch.valid <= 1'b0;
      end else begin
        next_req = source_bytes.pop_front();
        text_ch.valid        <= 1'b1;
        text_ch.in_byte      <= next_req.ch;
        text_ch.end_of_input <= next_req.eoi;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long hold-off of the result side, so that the block fills and stalls its input.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && accepted_count >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result side ready with random stall bursts.
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left--;
    end else if (source_bytes.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 18);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each taken request and checks each delivered result request.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst) begin
      text_taken = 1'b0;
    end else begin
      text_taken = text_ch.valid && text_ch.ready;
      if (text_taken) begin
        predict_request('{eoi: text_ch.end_of_input, ch: text_ch.in_byte});
        accepted_count++;
      end
      if (result_ch.valid && result_ch.ready) begin
        got = '{newline_before: result_ch.newline_before,
                spaces_before:  result_ch.spaces_before,
                has_byte:       result_ch.has_byte,
                out_byte:       result_ch.out_byte,
                last:           result_ch.last};
        if (expected_tokens.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_MAX)
            $display("unexpected token: nl=%0b sp=%0d has=%0b byte=%02h last=%0b",
                     got.newline_before, got.spaces_before, got.has_byte,
                     got.out_byte, got.last);
        end else begin
          if (got !== expected_tokens[0]) begin
            err_count++;
            if (err_count <= REPORT_MAX) begin
              $write("token mismatch: expected nl=%0b sp=%0d has=%0b byte=%02h last=%0b,",
                     expected_tokens[0].newline_before, expected_tokens[0].spaces_before,
                     expected_tokens[0].has_byte, expected_tokens[0].out_byte,
                     expected_tokens[0].last);
              $display(" got nl=%0b sp=%0d has=%0b byte=%02h last=%0b",
                       got.newline_before, got.spaces_before,
                       got.has_byte, got.out_byte, got.last);
            end
          end
          void'(expected_tokens.pop_front());
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, stimulus, drain and verdict.
  // ---------------------------------------------------------------------------

  initial begin
    rst                    = 1'b1;
    text_ch.valid          = 1'b0;
    text_ch.in_byte        = '0;
    text_ch.end_of_input   = 1'b0;
    result_ch.ready        = 1'b0;

    // Directed file: leading newline, blanks, lone slashes, an escaped quote in a string
    // ended by a newline, both comment forms with a star run, and a held slash at the end.
    add_text("\n a\t/b/\"\\\"\n//c\n/**z**/\n/");
    add_eoi();
    // Extreme byte values and a pending newline flushed alone.
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte(CH_NL);
    add_eoi();

    while (source_bytes.size() < ITEM_TARGET) add_file();

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Wait until every request is taken and every result request has come back.
    do @(posedge clk); while (source_bytes.size() != 0 || text_ch.valid);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0 && expected_tokens.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
